// ===== rtl/hsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hsd_pkg;

  // Node index field width and symbol width of the serialized tree.
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned TB_W   = 9;
  localparam int unsigned STAT_W = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN    = 1'd1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EARLY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADTREE = 2'd2;

  // Index of the first (most significant) bit of a byte, and symbol length.
  localparam logic [2:0] LAST_BIT  = 3'd7;
  localparam logic [3:0] LEAF_BITS = 4'd8;

  // One entry of the node memory. An inner node keeps its children,
  // a leaf keeps its symbol in the low bits of the right field.
  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

endpackage
`default_nettype wire

// ===== rtl/hsd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/huffman_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Static Huffman stream decoder. Compressed bytes enter one request at a time
// on the in_ channel and are consumed most significant bit first. The first
// bytes of the stream, as many as the header length register gives, carry a
// preorder-serialized code tree (0 = inner node,
// 1 = leaf followed by 8 symbol bits, trailing bits are padding) that is
// built into a node memory; the bytes after it are walked from the root and
// each leaf reached yields one result request carrying the symbol, status 0
// and the running count. Decoding stops after output_length symbols
// (end_of_output set). A malformed or overflowing tree, or a payload bit
// selecting an absent child, gives a single status 2 result; in_last on a
// byte that does not finish the stream gives a status 1 result. A tree whose
// header ends with the root's left subtree complete and its right subtree
// absent or unfinished is accepted with that right subtree dropped. After
// any end_of_output result the block swallows input until reset.
// Configuration writes are taken only while the block is idle. The block
// holds one byte at a time and stalls its input until that byte is
// finished. Header bytes are parsed one bit at a time, while a padding
// byte skips its bits; a payload byte is walked one bit at a time, since
// each tree step is one read of the node memory, whose read is registered.
// Each result is handed to the output register once that is free, so a
// stalling receiver holds the block. Finishing the header and every byte
// also pass through bookkeeping states (accept, dispatch and wrap-up).
module huffman_stream_decoder_unit #(
  parameter int unsigned NODE_DEPTH  = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Compressed byte input.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [hsd_pkg::SYM_W-1:0]        in_byte,
  input  wire logic                             in_last,
  // Decoded result output.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [hsd_pkg::SYM_W-1:0]        out_byte,
  output logic      [hsd_pkg::STAT_W-1:0]       out_status,
  output logic      [hsd_pkg::LEN_W-1:0]        out_decoded_total,
  output logic                                  out_end_of_output,
  // Configuration writes.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import hsd_pkg::*;

  localparam int unsigned NA = $clog2(NODE_DEPTH);
  localparam int unsigned CW = $clog2(NODE_DEPTH + 1);
  localparam int unsigned SA = $clog2(STACK_DEPTH);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_PARSE,
    PH_PAD,
    PH_PAY,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_HBIT,
    S_HCHILD,
    S_NEXT,
    S_BYTE_END,
    S_FIN,
    S_FIN2,
    S_PBIT,
    S_PCHILD,
    S_LAST,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt, ret_r, ret_nxt;
  phase_t              phase_r, phase_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [TB_W-1:0]     tb_r, tb_nxt;
  logic [SYM_W-1:0]    byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic [2:0]          bit_i_r, bit_i_nxt;
  logic [3:0]          leaf_bits_r, leaf_bits_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [SW-1:0]       stk_r, stk_nxt;
  logic [IDX_W-1:0]    top_r, top_nxt;
  logic                pop_r, pop_nxt;
  logic [TB_W-1:0]     pos_r, pos_nxt;
  logic                fin_pre_r, fin_pre_nxt;
  node_t               cur_r, cur_nxt;
  node_t               root_r, root_nxt;
  logic [LEN_W-1:0]    dec_r, dec_nxt;
  logic [SYM_W-1:0]    res_byte_r, res_byte_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  logic                res_end_r, res_end_nxt;
  logic                ov_r, ov_nxt;
  logic [SYM_W-1:0]    ob_r, ob_nxt;
  logic [STAT_W-1:0]   os_r, os_nxt;
  logic [LEN_W-1:0]    ot_r, ot_nxt;
  logic                oe_r, oe_nxt;

  // Node memory and pending-node stack ports.
  logic                node_we;
  logic [NA-1:0]       node_waddr, node_raddr;
  node_t               node_wdata, node_rdata;
  logic                stk_we;
  logic [SA-1:0]       stk_waddr, stk_raddr;
  logic [IDX_W-1:0]    stk_wdata, stk_rdata;

  // Helpers.
  logic                cur_bit;
  logic [CW-1:0]       cnt_m1;
  logic [SW-1:0]       stk_m1, stk_m2;
  logic [IDX_W:0]      top_inc;
  logic [IDX_W-1:0]    cnt9;
  logic [TB_W-1:0]     pos_inc;
  logic [LEN_W-1:0]    dec_inc;
  logic [IDX_W-1:0]    child;
  logic                do_sym, do_fail;
  logic [SYM_W-1:0]    sym_val;
  logic [STAT_W-1:0]   fail_st;
  logic                slot_free;

  hsd_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_addr (node_raddr),
    .rd_data (node_rdata)
  );

  hsd_ram #(
    .WIDTH (IDX_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign cur_bit   = byte_r[LAST_BIT - bit_i_r];
  assign cnt_m1    = cnt_r - CW'(1);
  assign stk_m1    = stk_r - SW'(1);
  assign stk_m2    = stk_r - SW'(2);
  assign top_inc   = {1'b0, top_r} + (IDX_W+1)'(1);
  assign cnt9      = IDX_W'(cnt_r);
  assign pos_inc   = pos_r + TB_W'(1);
  assign dec_inc   = dec_r + LEN_W'(1);
  assign child     = cur_bit ? cur_r.right : cur_r.left;
  assign slot_free = !ov_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    phase_nxt     = phase_r;
    out_len_nxt   = out_len_r;
    tb_nxt        = tb_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    bit_i_nxt     = bit_i_r;
    leaf_bits_nxt = leaf_bits_r;
    sym_nxt       = sym_r;
    cnt_nxt       = cnt_r;
    stk_nxt       = stk_r;
    top_nxt       = top_r;
    pop_nxt       = pop_r;
    pos_nxt       = pos_r;
    fin_pre_nxt   = fin_pre_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    dec_nxt       = dec_r;
    res_byte_nxt  = res_byte_r;
    res_stat_nxt  = res_stat_r;
    res_end_nxt   = res_end_r;
    ov_nxt        = ov_r && out_stall;
    ob_nxt        = ob_r;
    os_nxt        = os_r;
    ot_nxt        = ot_r;
    oe_nxt        = oe_r;
    node_we       = 1'b0;
    node_waddr    = '0;
    node_wdata    = '0;
    node_raddr    = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_raddr     = '0;
    do_sym        = 1'b0;
    do_fail       = 1'b0;
    sym_val       = '0;
    fail_st       = ST_BADTREE;

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          case (cfg_index)
            CFG_OUTPUT_LENGTH: out_len_nxt = cfg_data;
            CFG_HEADER_LEN:    tb_nxt = cfg_data[TB_W-1:0];
            default: ;
          endcase
        end
        if (in_valid) begin
          byte_nxt  = in_byte;
          last_nxt  = in_last;
          bit_i_nxt = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (phase_r == PH_DONE) begin
          state_nxt = S_IDLE;
        end else if (phase_r == PH_PAY) begin
          state_nxt = S_PBIT;
        end else if (pos_r >= tb_r) begin
          fin_pre_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else if (phase_r == PH_PAD) begin
          state_nxt = S_BYTE_END;
        end else begin
          state_nxt = S_HBIT;
        end
      end
      S_HBIT: begin
        if (leaf_bits_r != '0) begin
          // Shift one symbol bit into the leaf being built.
          sym_nxt       = {sym_r[SYM_W-2:0], cur_bit};
          node_we       = 1'b1;
          node_waddr    = cnt_m1[NA-1:0];
          node_wdata    = '{leaf: 1'b1, left: '0, right: IDX_W'(sym_nxt)};
          leaf_bits_nxt = leaf_bits_r - 4'd1;
          if (leaf_bits_r == 4'd1 && stk_r == '0) begin
            phase_nxt = PH_PAD;
          end
          state_nxt = S_NEXT;
        end else if (cnt_r >= CW'(NODE_DEPTH)) begin
          do_fail = 1'b1;
        end else if (cnt_r != '0 && stk_r == '0) begin
          do_fail = 1'b1;
        end else if (cnt_r != '0) begin
          // Attach the new node to the pending parent. The left child of a
          // node always directly follows it in preorder.
          node_we    = 1'b1;
          node_waddr = top_r[NA-1:0];
          if ((IDX_W+1)'(cnt_r) == top_inc) begin
            node_wdata = '{leaf: 1'b0, left: cnt9, right: '0};
            pop_nxt    = 1'b0;
          end else begin
            node_wdata = '{leaf: 1'b0, left: top_inc[IDX_W-1:0], right: cnt9};
            stk_nxt    = stk_m1;
            stk_raddr  = stk_m2[SA-1:0];
            pop_nxt    = 1'b1;
          end
          state_nxt = S_HCHILD;
        end else begin
          pop_nxt   = 1'b0;
          state_nxt = S_HCHILD;
        end
      end
      S_HCHILD: begin
        if (pop_r) begin
          top_nxt = stk_rdata;
        end
        if (cur_bit) begin
          node_we       = 1'b1;
          node_waddr    = cnt_r[NA-1:0];
          node_wdata    = '{leaf: 1'b1, left: '0, right: '0};
          sym_nxt       = '0;
          leaf_bits_nxt = LEAF_BITS;
          cnt_nxt       = cnt_r + CW'(1);
          state_nxt     = S_NEXT;
        end else if (stk_r >= SW'(STACK_DEPTH)) begin
          do_fail = 1'b1;
        end else begin
          node_we    = 1'b1;
          node_waddr = cnt_r[NA-1:0];
          node_wdata = '0;
          stk_we     = 1'b1;
          stk_waddr  = stk_r[SA-1:0];
          stk_wdata  = cnt9;
          top_nxt    = cnt9;
          stk_nxt    = stk_r + SW'(1);
          cnt_nxt    = cnt_r + CW'(1);
          state_nxt  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (bit_i_r == LAST_BIT) begin
          state_nxt = (phase_r == PH_PAY) ? S_LAST : S_BYTE_END;
        end else begin
          bit_i_nxt = bit_i_r + 3'd1;
          case (phase_r)
            PH_PARSE: state_nxt = S_HBIT;
            PH_PAY:   state_nxt = S_PBIT;
            default:  state_nxt = S_BYTE_END;
          endcase
        end
      end
      S_BYTE_END: begin
        pos_nxt = pos_inc;
        if (pos_inc >= tb_r) begin
          fin_pre_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_FIN: begin
        if (phase_r == PH_PARSE && cnt_r == '0) begin
          do_fail = 1'b1;
        end else begin
          node_raddr = '0;
          state_nxt  = S_FIN2;
        end
      end
      S_FIN2: begin
        if (phase_r == PH_PARSE && (node_rdata.leaf || node_rdata.left == '0 ||
            (node_rdata.right == '0 && !(stk_r == SW'(1) && leaf_bits_r == '0)))) begin
          do_fail = 1'b1;
        end else begin
          // An unfinished header keeps only the root's complete left subtree:
          // drop the root's right subtree.
          if (phase_r == PH_PARSE) begin
            node_we    = 1'b1;
            node_waddr = '0;
            node_wdata = '{leaf: 1'b0, left: node_rdata.left, right: '0};
            root_nxt   = '{leaf: 1'b0, left: node_rdata.left, right: '0};
            cur_nxt    = '{leaf: 1'b0, left: node_rdata.left, right: '0};
          end else begin
            root_nxt = node_rdata;
            cur_nxt  = node_rdata;
          end
          phase_nxt     = PH_PAY;
          stk_nxt       = '0;
          leaf_bits_nxt = '0;
          state_nxt     = fin_pre_r ? S_PBIT : S_LAST;
        end
      end
      S_PBIT: begin
        if (cur_r.leaf) begin
          do_sym  = 1'b1;
          sym_val = cur_r.right[SYM_W-1:0];
        end else if (child == '0) begin
          do_fail = 1'b1;
        end else begin
          node_raddr = child[NA-1:0];
          state_nxt  = S_PCHILD;
        end
      end
      S_PCHILD: begin
        if (node_rdata.leaf) begin
          cur_nxt = root_r;
          do_sym  = 1'b1;
          sym_val = node_rdata.right[SYM_W-1:0];
        end else begin
          cur_nxt   = node_rdata;
          state_nxt = S_NEXT;
        end
      end
      S_LAST: begin
        if (last_r) begin
          do_fail = 1'b1;
          fail_st = ST_EARLY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = res_byte_r;
          os_nxt    = res_stat_r;
          ot_nxt    = dec_r;
          oe_nxt    = res_end_r;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_sym) begin
      dec_nxt      = dec_inc;
      res_byte_nxt = sym_val;
      res_stat_nxt = ST_OK;
      state_nxt    = S_EMIT;
      if (dec_inc >= out_len_r) begin
        res_end_nxt = 1'b1;
        phase_nxt   = PH_DONE;
        ret_nxt     = S_IDLE;
      end else begin
        res_end_nxt = 1'b0;
        ret_nxt     = S_NEXT;
      end
    end
    if (do_fail) begin
      res_byte_nxt = '0;
      res_stat_nxt = fail_st;
      res_end_nxt  = 1'b1;
      phase_nxt    = PH_DONE;
      ret_nxt      = S_IDLE;
      state_nxt    = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      phase_r     <= PH_PARSE;
      out_len_r   <= LEN_W'(1);
      tb_r        <= TB_W'(2);
      byte_r      <= '0;
      last_r      <= 1'b0;
      bit_i_r     <= '0;
      leaf_bits_r <= '0;
      sym_r       <= '0;
      cnt_r       <= '0;
      stk_r       <= '0;
      top_r       <= '0;
      pop_r       <= 1'b0;
      pos_r       <= '0;
      fin_pre_r   <= 1'b0;
      cur_r       <= '0;
      root_r      <= '0;
      dec_r       <= '0;
      res_byte_r  <= '0;
      res_stat_r  <= ST_OK;
      res_end_r   <= 1'b0;
      ov_r        <= 1'b0;
      ob_r        <= '0;
      os_r        <= ST_OK;
      ot_r        <= '0;
      oe_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      phase_r     <= phase_nxt;
      out_len_r   <= out_len_nxt;
      tb_r        <= tb_nxt;
      byte_r      <= byte_nxt;
      last_r      <= last_nxt;
      bit_i_r     <= bit_i_nxt;
      leaf_bits_r <= leaf_bits_nxt;
      sym_r       <= sym_nxt;
      cnt_r       <= cnt_nxt;
      stk_r       <= stk_nxt;
      top_r       <= top_nxt;
      pop_r       <= pop_nxt;
      pos_r       <= pos_nxt;
      fin_pre_r   <= fin_pre_nxt;
      cur_r       <= cur_nxt;
      root_r      <= root_nxt;
      dec_r       <= dec_nxt;
      res_byte_r  <= res_byte_nxt;
      res_stat_r  <= res_stat_nxt;
      res_end_r   <= res_end_nxt;
      ov_r        <= ov_nxt;
      ob_r        <= ob_nxt;
      os_r        <= os_nxt;
      ot_r        <= ot_nxt;
      oe_r        <= oe_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_byte          = ob_r;
  assign out_status        = os_r;
  assign out_decoded_total = ot_r;
  assign out_end_of_output = oe_r;

`ifndef SYNTHESIS
  // Once the stream has ended, the block never leaves the finished phase.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("decoder left the finished phase");

  // The pending stack never holds more than its capacity.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_r <= SW'(STACK_DEPTH))
    else $error("pending stack overran its depth");

  // The node count never exceeds the node memory.
  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NODE_DEPTH))
    else $error("node count overran the node memory");

  // A result is only loaded while the output slot is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && ov_r && out_stall) |=> (ov_r && $stable(ot_r)))
    else $error("stalled result was overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/hsd_checker.sv =====
`timescale 1ns / 1ps
module hsd_checker #(
  parameter int unsigned NODE_DEPTH  = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [hsd_pkg::SYM_W-1:0]          in_byte,
  input  logic                               in_last,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [hsd_pkg::SYM_W-1:0]          out_byte,
  input  logic [hsd_pkg::STAT_W-1:0]         out_status,
  input  logic [hsd_pkg::LEN_W-1:0]          out_decoded_total,
  input  logic                               out_end_of_output,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [hsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import hsd_pkg::*;

  typedef enum logic [1:0] {
    PH_TREE    = 2'd0,
    PH_PAD     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DONE    = 2'd3
  } dec_phase_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  total;
    logic              eoo;
  } symbol_result_t;

  symbol_result_t   symbol_q[$];

  node_t            tree_mem[512];
  logic [IDX_W-1:0] open_nodes[256];
  int unsigned      open_lvl;
  int unsigned      node_cnt;
  dec_phase_t       dphase;
  int unsigned      sym_bits_left;
  logic [8:0]       hdr_pos;
  logic [IDX_W-1:0] walk;
  logic [31:0]      decoded;
  logic [31:0]      length_reg;
  logic [8:0]       hdr_len_reg;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic push_symbol(logic [7:0] sym, logic [1:0] st, logic eoo);
    symbol_q.push_back('{sym: sym, status: st, total: decoded, eoo: eoo});
  endtask

  task automatic abort_stream(logic [1:0] st);
    push_symbol(8'd0, st, 1'b1);
    dphase = PH_DONE;
  endtask

  // One bit of the serialized tree; returns 1 when the tree overflows or is malformed.
  function automatic bit tree_bit(bit b);
    int unsigned idx;
    int unsigned top;
    node_t e;
    if (sym_bits_left != 0) begin
      idx = (node_cnt - 1) % 512;
      e = tree_mem[idx];
      e.right[7:0] = {e.right[6:0], b};
      tree_mem[idx] = e;
      sym_bits_left--;
      if (sym_bits_left == 0 && open_lvl == 0) dphase = PH_PAD;
      return 1'b0;
    end
    if (node_cnt >= NODE_DEPTH) return 1'b1;
    idx = node_cnt;
    if (idx != 0) begin
      if (open_lvl == 0) return 1'b1;
      top = open_nodes[open_lvl - 1];
      e = tree_mem[top];
      if (e.left == 0) begin
        e.left = IDX_W'(idx);
      end else begin
        e.right = IDX_W'(idx);
        open_lvl--;
      end
      tree_mem[top] = e;
    end
    if (b) begin
      tree_mem[idx] = '{leaf: 1'b1, left: '0, right: '0};
      sym_bits_left = 8;
    end else begin
      if (open_lvl >= STACK_DEPTH) return 1'b1;
      tree_mem[idx] = '0;
      open_nodes[open_lvl] = IDX_W'(idx);
      open_lvl++;
    end
    node_cnt++;
    return 1'b0;
  endfunction

  // Closes the header; returns 1 when the tree is unusable.
  function automatic bit close_header();
    node_t r;
    if (dphase == PH_TREE) begin
      if (node_cnt == 0) return 1'b1;
      r = tree_mem[0];
      if (r.leaf || r.left == 0) return 1'b1;
      if (r.right == 0 && !(open_lvl == 1 && sym_bits_left == 0)) return 1'b1;
      r.right = '0;
      tree_mem[0] = r;
    end
    dphase = PH_PAYLOAD;
    walk = '0;
    open_lvl = 0;
    sym_bits_left = 0;
    return 1'b0;
  endfunction

  task automatic decode_byte(logic [7:0] data, logic last);
    bit b;
    node_t e;
    node_t ce;
    logic [IDX_W-1:0] child;
    logic [7:0] sym;
    if (dphase == PH_DONE) return;
    if (dphase <= PH_PAD && hdr_pos >= hdr_len_reg && close_header()) begin
      abort_stream(ST_BADTREE);
      return;
    end
    if (dphase <= PH_PAD) begin
      for (int i = 0; i < 8; i++) begin
        b = data[7 - i];
        if (dphase == PH_TREE && tree_bit(b)) begin
          abort_stream(ST_BADTREE);
          return;
        end
      end
      hdr_pos = hdr_pos + 9'd1;
      if (hdr_pos >= hdr_len_reg && close_header()) begin
        abort_stream(ST_BADTREE);
        return;
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        b = data[7 - i];
        e = tree_mem[walk];
        if (e.leaf) begin
          sym = e.right[7:0];
          walk = '0;
        end else begin
          child = b ? e.right : e.left;
          if (child == 0) begin
            abort_stream(ST_BADTREE);
            return;
          end
          ce = tree_mem[child];
          if (!ce.leaf) begin
            walk = child;
            continue;
          end
          sym = ce.right[7:0];
          walk = '0;
        end
        decoded++;
        if (decoded >= length_reg) begin
          push_symbol(sym, ST_OK, 1'b1);
          dphase = PH_DONE;
          return;
        end
        push_symbol(sym, ST_OK, 1'b0);
      end
    end
    if (last) abort_stream(ST_EARLY);
  endtask

  always @(posedge clk) begin
    symbol_result_t want;
    if (!rst_n) begin
      symbol_q.delete();
      open_lvl      = 0;
      node_cnt      = 0;
      dphase        = PH_TREE;
      sym_bits_left = 0;
      hdr_pos       = '0;
      walk          = '0;
      decoded       = '0;
      length_reg    = 32'd1;
      hdr_len_reg   = 9'd2;
      fail_count    = 0;
      pending       <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (symbol_q.size() == 0) begin
          report("unexpected result, byte", out_byte, 0);
        end else begin
          want = symbol_q.pop_front();
          if (out_byte !== want.sym) report("out_byte", out_byte, want.sym);
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_decoded_total !== want.total)
            report("decoded_total", out_decoded_total, want.total);
          if (out_end_of_output !== want.eoo)
            report("end_of_output", out_end_of_output, want.eoo);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OUTPUT_LENGTH: length_reg = cfg_data;
          CFG_HEADER_LEN:    hdr_len_reg = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_byte, in_last);
      pending <= symbol_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import hsd_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SYM_W-1:0]      in_byte;
  logic                  in_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [SYM_W-1:0]      out_byte;
  logic [STAT_W-1:0]     out_status;
  logic [LEN_W-1:0]      out_decoded_total;
  logic                  out_end_of_output;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // When quiet is set, neither side inserts idle cycles.
  bit                    quiet;
  // Each increment of hold_asks requests one long receiver hold-off.
  int                    hold_asks;

  huffman_stream_decoder_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_status(out_status), .out_decoded_total(out_decoded_total),
    .out_end_of_output(out_end_of_output),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  hsd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_status(out_status), .out_decoded_total(out_decoded_total),
    .out_end_of_output(out_end_of_output),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog. A correct run needs well under a millisecond.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver side. Normally it stalls in short random bursts. When a long
  // hold-off is requested it keeps stalling, which lets the block fill up
  // and push back on the sender.
  always @(negedge clk) begin
    int hold_left;
    int burst_left;
    int served;
    if (!rst_n) begin
      out_stall = 1'b0;
      hold_left = 0;
      burst_left = 0;
      served = 0;
    end else if (served != hold_asks) begin
      served = hold_asks;
      hold_left = 400;
      out_stall = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(5) == 0) begin
      burst_left = $urandom_range(2);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Offers one compressed byte at the current falling edge and returns at
  // the falling edge after it was taken, sometimes after a short idle gap.
  task automatic send_byte(logic [7:0] data, logic last);
    in_valid = 1'b1;
    in_byte = data;
    in_last = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!quiet && $urandom_range(4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Configuration is only written while the block is idle. Header bytes give
  // no results, so after the last expected result the block may still be
  // busy; a fixed margin covers the worst byte time.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    bit             hdr_bits[$];
    int             open_slots;
    int             leaves;
    int             leaf_cap;
    int             hdr_len;
    logic [7:0]     sym;
    logic [7:0]     data;
    logic [7:0]     directed[10];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_asks = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Build a random complete code tree in preorder form. The root is always
    // an inner node, the first two leaves carry the extreme symbol values and
    // the leaf count is capped so the header stays a few dozen bytes.
    leaf_cap = $urandom_range(2, 40);
    open_slots = 1;
    leaves = 0;
    while (open_slots > 0) begin
      if (hdr_bits.size() == 0 ||
          (open_slots + leaves < leaf_cap && $urandom_range(1) == 0)) begin
        hdr_bits.push_back(1'b0);
        open_slots++;
      end else begin
        sym = (leaves == 0) ? 8'h00 : (leaves == 1) ? 8'hFF : 8'($urandom);
        hdr_bits.push_back(1'b1);
        for (int i = 7; i >= 0; i--) hdr_bits.push_back(sym[i]);
        open_slots--;
        leaves++;
      end
    end
    // Whole padding bytes after the tree are ignored just like the tail of
    // its last byte.
    hdr_len = (hdr_bits.size() + 7) / 8 + $urandom_range(0, 2);
    while (hdr_bits.size() < hdr_len * 8) hdr_bits.push_back(1'($urandom));

    // A large header length first, then the real one; decoding starts
    // with the longest possible output.
    cfg_write(CFG_HEADER_LEN, 32'd320);
    cfg_write(CFG_OUTPUT_LENGTH, 32'hFFFF_FFFF);
    cfg_write(CFG_HEADER_LEN, CFG_DATA_W'(hdr_len));

    for (int b = 0; b < hdr_len; b++) begin
      for (int i = 0; i < 8; i++) data[7 - i] = hdr_bits[b * 8 + i];
      send_byte(data, 1'b0);
    end

    // Directed payload: all zeros and all ones walk the outer edges of the
    // tree, the alternating patterns mix both branches on every level.
    directed = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h80, 8'h01, 8'h7F, 8'hFE};
    foreach (directed[i]) send_byte(directed[i], 1'b0);

    // The sender pauses until every result is out. The header length is
    // then moved back to its reset value of two, which no longer matters once the
    // payload runs, and the output length drops by one.
    wait_idle();
    cfg_write(CFG_HEADER_LEN, 32'd2);
    cfg_write(CFG_OUTPUT_LENGTH, 32'hFFFF_FFFE);

    // Random payload. Early on the receiver holds off for a long stretch
    // while the sender keeps offering bytes. A stretch in the middle and
    // the tail run with no idle cycles at all.
    for (int n = 0; n < 440; n++) begin
      if (n == 20) hold_asks++;
      quiet = (n >= 200 && n < 250) || n >= 380;
      send_byte(8'($urandom), 1'b0);
    end

    // Close the stream. Half of the runs set a zero output length first, so
    // the next decoded symbol ends the stream and the final byte is
    // swallowed; otherwise the final byte reports an early end.
    wait_idle();
    if ($urandom_range(1) == 0) cfg_write(CFG_OUTPUT_LENGTH, 32'd0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    in_valid = 1'b0;
    in_last = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
